// ===== hdl/stbg_pkg.sv =====
// Package for the sine tone burst generator: sizes, register indexes, controller
// states, command/status structs and the quarter-wave sine table.
// Used by stbg_controller, stbg_datapath and sine_tone_burst_generator.
`default_nettype none

package stbg_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_SIZE    = 1 << (SINE_TABLE_BITS - 2);
   localparam int ROM_ADDR_BITS   = SINE_TABLE_BITS - 1;

   localparam int PHASE_BITS  = 32;
   localparam int LENGTH_BITS = 20;
   localparam int INDEX_BITS  = 21;
   localparam int SAMPLE_BITS = 16;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURST_LENGTH = CSR_INDEX_BITS'(1);

   localparam int TONE_AMPLITUDE = 26000;
   localparam int RAMP_SAMPLES   = 320;
   localparam int FACTOR_BITS    = 9;
   localparam int PROD_BITS      = SAMPLE_BITS + FACTOR_BITS;

   // Division by 320 is a shift by 6 followed by division by 5, done as a
   // multiply by ceil(2^18/5); this is exact for every product that can occur.
   localparam int RAMP_SHIFT        = 6;
   localparam int SCALED_BITS       = PROD_BITS - RAMP_SHIFT;
   localparam int RECIP_MULT        = 52429;
   localparam int RECIP_MULT_BITS   = 16;
   localparam int RECIP_SHIFT       = 18;
   localparam int RECIP_BITS        = SCALED_BITS + RECIP_MULT_BITS;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   typedef logic [QUARTER_SIZE-1:0][SAMPLE_BITS-1:0] sine_rom_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MULTIPLY,
      ST_DIVIDE,
      ST_FINISH
   } stbg_state_type;

   typedef struct packed {
      logic accept;
      logic lookup;
      logic multiply;
      logic divide;
      logic commit;
   } stbg_cmd_type;

   typedef struct packed {
      logic out_free;
   } stbg_status_type;

   // Truncating quotient by shift and subtract, used only while the table is built.
   function automatic longint unsigned quotient(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = 64'd0;
      quo = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Entry k holds 26000*sin(pi/2*k/Q) from a Q30 Taylor series through x^11.
   function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned div;
      int unsigned     n;
      x    = (HALF_PI_Q30 * 64'(k)) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n <= 5; n++) begin
         div  = 64'(2 * n) * 64'(2 * n + 1);
         term = quotient((term * x2) >> 30, div);
         if (n[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return SAMPLE_BITS'((sum * 64'(TONE_AMPLITUDE) + (ONE_Q30 >> 1)) >> 30);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      int unsigned  k;
      for (k = 0; k < QUARTER_SIZE; k++) begin
         rom[k] = sine_entry(k);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [SAMPLE_BITS-1:0] SINE_PEAK = sine_entry(QUARTER_SIZE);

endpackage

`default_nettype wire

// ===== hdl/stbg_controller.sv =====
// Sequencer of the sine tone burst generator: steps one transaction through
// lookup, multiply, divide and finish. Depends on stbg_pkg.
`default_nettype none

module stbg_controller (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  stbg_pkg::stbg_status_type      status,
   output stbg_pkg::stbg_cmd_type         cmd
);

   stbg_pkg::stbg_state_type state_ff;
   stbg_pkg::stbg_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         stbg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stbg_pkg::ST_LOOKUP;
            end
         end
         stbg_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = stbg_pkg::ST_MULTIPLY;
         end
         stbg_pkg::ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = stbg_pkg::ST_DIVIDE;
         end
         stbg_pkg::ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = stbg_pkg::ST_FINISH;
         end
         stbg_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = stbg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/stbg_datapath.sv =====
// Datapath of the sine tone burst generator: configuration registers, phase and
// index state, sine table lookup, envelope scaling and the result register.
// Depends on stbg_pkg.
`default_nettype none

module stbg_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_start_req,
   input  stbg_pkg::stbg_cmd_type                       cmd,
   output stbg_pkg::stbg_status_type                    status,
   input  wire logic                                    csr_write,
   input  wire logic [stbg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [stbg_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [stbg_pkg::SAMPLE_BITS-1:0]      rsp_sample,
   output logic                                         rsp_active,
   output logic                                         rsp_last
);

   localparam int TB = stbg_pkg::SINE_TABLE_BITS;
   localparam int AB = stbg_pkg::ROM_ADDR_BITS;
   localparam logic [AB-1:0] QUARTER_ADDR = AB'(stbg_pkg::QUARTER_SIZE);

   logic [stbg_pkg::PHASE_BITS-1:0]  phase_step_ff, phase_step_in;
   logic [stbg_pkg::LENGTH_BITS-1:0] burst_length_ff, burst_length_in;
   logic [stbg_pkg::PHASE_BITS-1:0]  phase_acc_ff, phase_acc_in;
   logic [stbg_pkg::INDEX_BITS-1:0]  sample_index_ff, sample_index_in;
   logic                             burst_on_ff, burst_on_in;

   logic [stbg_pkg::SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic                             neg_ff, neg_in;
   logic                             env_ff, env_in;
   logic                             fin_ff, fin_in;
   logic [stbg_pkg::FACTOR_BITS-1:0] factor_ff, factor_in;
   logic [stbg_pkg::PROD_BITS-1:0]   prod_ff, prod_in;
   logic [stbg_pkg::RECIP_BITS-1:0]  recip_ff, recip_in;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [stbg_pkg::SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                    rsp_active_ff, rsp_active_in;
   logic                                    rsp_last_ff, rsp_last_in;

   logic [TB-1:0]                    phase_top;
   logic [1:0]                       quad;
   logic [AB-1:0]                    rom_addr;
   logic [stbg_pkg::SAMPLE_BITS-1:0] rom_data;
   logic [stbg_pkg::INDEX_BITS-1:0]  len_ext;
   logic [stbg_pkg::LENGTH_BITS-1:0] down_start;
   logic [stbg_pkg::INDEX_BITS-1:0]  down_num;
   logic                             ramp_up;
   logic                             ramp_down;
   logic [stbg_pkg::SAMPLE_BITS-1:0] mag_final;

   always_comb begin
      phase_top  = phase_acc_ff[stbg_pkg::PHASE_BITS-1 -: TB];
      quad       = phase_top[TB-1 -: 2];
      rom_addr   = quad[0] ? QUARTER_ADDR - {1'b0, phase_top[TB-3:0]}
                           : {1'b0, phase_top[TB-3:0]};
      rom_data   = rom_addr[AB-1] ? stbg_pkg::SINE_PEAK
                                  : stbg_pkg::SINE_ROM[rom_addr[AB-2:0]];
      len_ext    = {1'b0, burst_length_ff};
      down_start = burst_length_ff - stbg_pkg::LENGTH_BITS'(stbg_pkg::RAMP_SAMPLES);
      ramp_up    = sample_index_ff < stbg_pkg::INDEX_BITS'(stbg_pkg::RAMP_SAMPLES);
      ramp_down  = (burst_length_ff >= stbg_pkg::LENGTH_BITS'(stbg_pkg::RAMP_SAMPLES)) &&
                   (sample_index_ff > {1'b0, down_start});
      down_num   = (len_ext > sample_index_ff) ? len_ext - sample_index_ff : '0;
      mag_final  = env_ff ? recip_ff[stbg_pkg::RECIP_SHIFT +: stbg_pkg::SAMPLE_BITS] : mag_ff;
   end

   always_comb begin
      phase_step_in   = phase_step_ff;
      burst_length_in = burst_length_ff;
      phase_acc_in    = phase_acc_ff;
      sample_index_in = sample_index_ff;
      burst_on_in     = burst_on_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      env_in          = env_ff;
      fin_in          = fin_ff;
      factor_in       = factor_ff;
      prod_in         = prod_ff;
      recip_in        = recip_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         if (csr_index == stbg_pkg::CSR_PHASE_STEP) begin
            phase_step_in = csr_wdata[stbg_pkg::PHASE_BITS-1:0];
         end else if (csr_index == stbg_pkg::CSR_BURST_LENGTH) begin
            burst_length_in = csr_wdata[stbg_pkg::LENGTH_BITS-1:0];
         end
      end

      if (cmd.accept && req_start_req) begin
         phase_acc_in    = '0;
         sample_index_in = '0;
         burst_on_in     = (burst_length_ff != '0);
      end

      if (cmd.lookup) begin
         mag_in = rom_data;
         neg_in = quad[1];
         env_in = ramp_up || ramp_down;
         fin_in = ({1'b0, sample_index_ff} + 1'b1) >= {2'b0, burst_length_ff};
         factor_in = ramp_up ? sample_index_ff[stbg_pkg::FACTOR_BITS-1:0]
                             : down_num[stbg_pkg::FACTOR_BITS-1:0];
      end

      if (cmd.multiply) begin
         prod_in = stbg_pkg::PROD_BITS'(mag_ff) * stbg_pkg::PROD_BITS'(factor_ff);
      end

      if (cmd.divide) begin
         recip_in = stbg_pkg::RECIP_BITS'(prod_ff[stbg_pkg::PROD_BITS-1:stbg_pkg::RAMP_SHIFT]) *
                    stbg_pkg::RECIP_BITS'(stbg_pkg::RECIP_MULT);
      end

      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_active_in = burst_on_ff;
         rsp_last_in   = burst_on_ff && fin_ff;
         if (!burst_on_ff) begin
            rsp_sample_in = '0;
         end else if (neg_ff) begin
            rsp_sample_in = -$signed(mag_final);
         end else begin
            rsp_sample_in = $signed(mag_final);
         end
         if (burst_on_ff) begin
            phase_acc_in    = phase_acc_ff + phase_step_ff;
            sample_index_in = sample_index_ff + 1'b1;
            burst_on_in     = !fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         burst_length_ff <= '0;
         phase_acc_ff    <= '0;
         sample_index_ff <= '0;
         burst_on_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_step_ff   <= phase_step_in;
         burst_length_ff <= burst_length_in;
         phase_acc_ff    <= phase_acc_in;
         sample_index_ff <= sample_index_in;
         burst_on_ff     <= burst_on_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      env_ff        <= env_in;
      fin_ff        <= fin_in;
      factor_ff     <= factor_in;
      prod_ff       <= prod_in;
      recip_ff      <= recip_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_active      = rsp_active_ff;
   assign rsp_last        = rsp_last_ff;

   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !burst_on_ff |=> rsp_sample_ff == '0 && !rsp_last_ff && !rsp_active_ff)
      else $error("idle transaction produced a nonzero result");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && burst_on_ff && fin_ff |=> !burst_on_ff)
      else $error("burst continued after its last sample");

   a_sample_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff <= 16'sd26000 && rsp_sample_ff >= -16'sd26000)
      else $error("sample outside the tone amplitude");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || !rsp_stall)
      else $error("result register overwritten while held");

endmodule

`default_nettype wire

// ===== hdl/sine_tone_burst_generator.sv =====
// Sequence: a transaction accepted in the idle state passes the lookup, multiply
// and divide states; its result is loaded into the output register in the finish
// state, and a stalled output holds the sequencer there. A new transaction is
// taken only in the idle state, once the four-step sequencer (table lookup,
// envelope multiply, reciprocal multiply, result load) is through with the last.
// Reset: synchronous; clears configuration, phase, index and burst state and
// the output valid. The sine table is constant logic and needs no fill.
`default_nettype none

module sine_tone_burst_generator (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_start_req,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [stbg_pkg::SAMPLE_BITS-1:0]      rsp_sample,
   output logic                                         rsp_active,
   output logic                                         rsp_last,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [stbg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [stbg_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   stbg_pkg::stbg_cmd_type    cmd;
   stbg_pkg::stbg_status_type status;

   assign csr_ready = 1'b1;

   stbg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stbg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_start_req (req_start_req),
      .cmd           (cmd),
      .status        (status),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_active    (rsp_active),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
